// ----- sv/aofb_pkg.sv -----
// aofb_pkg: AES S-box, xtime, register indexes and front-to-back request type
// for the AES-128 OFB stream cipher core. No dependencies.
`default_nettype none
package aofb_pkg;

    localparam int unsigned CFG_KEY_HIGH = 0;
    localparam int unsigned CFG_KEY_LOW  = 1;
    localparam int unsigned CFG_IV_HIGH  = 2;
    localparam int unsigned CFG_IV_LOW   = 3;
    localparam int unsigned CFG_IDX_W    = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } req_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] r;
        unique case (x)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

endpackage
`default_nettype wire

// ----- sv/aes128_ofb_stream_cipher_core.sv -----
// aes128_ofb_stream_cipher_core: top level of the AES-128 OFB byte cipher.
// Depends on aofb_pkg, aofb_queue, aofb_back (and aofb_round below it).
`default_nettype none
// AES-128 output feedback cipher, one byte per request. Encrypt and decrypt
// are the same operation. Bytes 1 to 15 of a block go from the queue head
// to the output register without an encryption. The first byte of every
// block (and any byte with restart set, or the first byte after reset)
// waits for one AES-128 encryption: 10 rounds on one shared round unit,
// one round per cycle. A two-entry request queue lets the input side keep
// taking requests while the cipher runs. The output register lets a
// finished byte wait under stall; the next request moves in at the edge
// where the waiting byte leaves.
// Key register writes apply at the next block encrypted; IV writes apply at
// the next restart. Configure only while the core is idle.
module aes128_ofb_stream_cipher_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [aofb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        restart,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       result_byte
);
    logic [63:0]    key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    aofb_pkg::req_t in_req, q_req;
    logic           q_valid, q_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= 64'd0;
            key_low_reg  <= 64'd0;
            iv_high_reg  <= 64'd0;
            iv_low_reg   <= 64'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                2'(aofb_pkg::CFG_KEY_HIGH): key_high_reg <= cfg_data;
                2'(aofb_pkg::CFG_KEY_LOW):  key_low_reg  <= cfg_data;
                2'(aofb_pkg::CFG_IV_HIGH):  iv_high_reg  <= cfg_data;
                2'(aofb_pkg::CFG_IV_LOW):   iv_low_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_req.data_byte = data_byte;
    assign in_req.restart   = restart;

    aofb_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (q_valid),
        .out_take  (q_take),
        .out_req   (q_req)
    );

    aofb_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .key          ({key_high_reg, key_low_reg}),
        .iv           ({iv_high_reg, iv_low_reg}),
        .req_valid    (q_valid),
        .req          (q_req),
        .req_take     (q_take),
        .result_valid (out_valid),
        .result_stall (out_stall),
        .result_byte  (result_byte)
    );
endmodule
`default_nettype wire

// ----- sv/aofb_queue.sv -----
// aofb_queue: two-entry request queue between the accepting front and the
// cipher back end. Uses aofb_pkg::req_t.
`default_nettype none
module aofb_queue
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire aofb_pkg::req_t in_req,
    output logic               out_valid,
    input  wire logic          out_take,
    output aofb_pkg::req_t     out_req
);
    aofb_pkg::req_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_stall  = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_req   = mem_reg[rp_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && out_take;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ----- sv/aofb_round.sv -----
// aofb_round: iterative AES-128 encryption, one round per cycle with on-the-fly
// key expansion. Uses aofb_pkg (sbox, xtime).
`default_nettype none
module aofb_round
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [127:0] key,
    input  wire logic [127:0] block_in,
    output logic              busy,
    output logic              done,
    output logic [127:0]      block_out
);
    logic [127:0] st_reg, st_next, rk_reg, rk_next;
    logic [3:0]   rnd_reg;
    logic [7:0]   rc_reg;
    logic         busy_reg, done_reg;
    logic [7:0]   t [16];
    logic [7:0]   sr [16];
    logic [7:0]   mc [16];
    logic [31:0]  w0, w1, w2, w3, g;

    always_comb
    begin
        g  = {aofb_pkg::sbox(rk_reg[23:16]), aofb_pkg::sbox(rk_reg[15:8]),
              aofb_pkg::sbox(rk_reg[7:0]), aofb_pkg::sbox(rk_reg[31:24])}
             ^ {rc_reg, 24'h0};
        w0 = rk_reg[127:96] ^ g;
        w1 = rk_reg[95:64] ^ w0;
        w2 = rk_reg[63:32] ^ w1;
        w3 = rk_reg[31:0] ^ w2;
        rk_next = {w0, w1, w2, w3};
        for (int i = 0; i < 16; i++)
        begin
            t[i] = aofb_pkg::sbox(st_reg[127-8*i -: 8]);
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sr[4*c+r] = t[4*((c+r)%4)+r];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            mc[4*c]   = sr[4*c] ^ (sr[4*c]^sr[4*c+1]^sr[4*c+2]^sr[4*c+3])
                        ^ aofb_pkg::xtime(sr[4*c] ^ sr[4*c+1]);
            mc[4*c+1] = sr[4*c+1] ^ (sr[4*c]^sr[4*c+1]^sr[4*c+2]^sr[4*c+3])
                        ^ aofb_pkg::xtime(sr[4*c+1] ^ sr[4*c+2]);
            mc[4*c+2] = sr[4*c+2] ^ (sr[4*c]^sr[4*c+1]^sr[4*c+2]^sr[4*c+3])
                        ^ aofb_pkg::xtime(sr[4*c+2] ^ sr[4*c+3]);
            mc[4*c+3] = sr[4*c+3] ^ (sr[4*c]^sr[4*c+1]^sr[4*c+2]^sr[4*c+3])
                        ^ aofb_pkg::xtime(sr[4*c+3] ^ sr[4*c]);
        end
        for (int i = 0; i < 16; i++)
        begin
            st_next[127-8*i -: 8] = ((rnd_reg == 4'd10) ? sr[i] : mc[i])
                                    ^ rk_next[127-8*i -: 8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            st_reg <= block_in ^ key;
            rk_reg <= key;
        end
        else if (busy_reg)
        begin
            st_reg <= st_next;
            rk_reg <= rk_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rnd_reg  <= 4'd0;
            rc_reg   <= 8'h01;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= 4'd1;
                rc_reg   <= 8'h01;
            end
            else if (busy_reg)
            begin
                rc_reg  <= aofb_pkg::xtime(rc_reg);
                rnd_reg <= rnd_reg + 4'd1;
                if (rnd_reg == 4'd10)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign block_out = st_reg;
endmodule
`default_nettype wire

// ----- sv/aofb_back.sv -----
// aofb_back: takes queued requests, runs the block cipher when a new block
// begins, XORs keystream and holds the result register. Uses aofb_round, aofb_pkg.
`default_nettype none
module aofb_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [127:0]   key,
    input  wire logic [127:0]   iv,
    input  wire logic           req_valid,
    input  wire aofb_pkg::req_t req,
    output logic                req_take,
    output logic                result_valid,
    input  wire logic           result_stall,
    output logic [7:0]          result_byte
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ENC  = 2'd1;

    logic [1:0]   state_reg, state_next;
    logic [127:0] fb_reg;
    logic [3:0]   pos_reg;
    logic         started_reg;
    logic [7:0]   out_reg;
    logic         oval_reg;
    logic         out_free, new_msg, need_enc;
    logic         enc_start, enc_busy, enc_done;
    logic [127:0] enc_in, enc_out, ks_block;
    logic [7:0]   ks_byte;

    assign out_free  = !oval_reg || !result_stall;
    assign new_msg   = req.restart || !started_reg;
    assign need_enc  = new_msg || (pos_reg == 4'd0);
    assign enc_in    = new_msg ? iv : fb_reg;
    assign enc_start = (state_reg == ST_IDLE) && req_valid && out_free && need_enc;
    assign ks_block  = (state_reg == ST_ENC) ? enc_out : fb_reg;
    assign ks_byte   = ks_block[127 - 8*((state_reg == ST_ENC) ? 4'd0 : pos_reg) -: 8];

    always_comb
    begin
        req_take   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && out_free)
                begin
                    if (need_enc) state_next = ST_ENC;
                    else          req_take = 1'b1;
                end
            end
            ST_ENC:
            begin
                if (enc_done)
                begin
                    req_take   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    aofb_round u_round
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (enc_start),
        .key       (key),
        .block_in  (enc_in),
        .busy      (enc_busy),
        .done      (enc_done),
        .block_out (enc_out)
    );

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            out_reg <= req.data_byte ^ ks_byte;
            if (state_reg == ST_ENC) fb_reg <= enc_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pos_reg     <= 4'd0;
            started_reg <= 1'b0;
            oval_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (req_take)
            begin
                oval_reg    <= 1'b1;
                started_reg <= 1'b1;
                pos_reg     <= ((state_reg == ST_ENC) ? 4'd0 : pos_reg) + 4'd1;
            end
            else if (!result_stall && !enc_busy)
            begin
                oval_reg <= 1'b0;
            end
            else if (!result_stall)
            begin
                oval_reg <= 1'b0;
            end
        end
    end

    assign result_valid = oval_reg;
    assign result_byte  = out_reg;
endmodule
`default_nettype wire
